/* hw/rtl/spc_pkg.sv */
// Shared types, constants and command codes for the slot pool with compaction.
`default_nettype none

package spc_pkg;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int HANDLE_BITS_DEFAULT = 32;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int EXT_HANDLE_W = 32;
  localparam int COUNT_W    = 5;

  localparam logic [COUNT_W-1:0] SLOTS_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_COMPACT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_CHK,
    ST_APP_SCAN,
    ST_CLR_CHK,
    ST_RD_CHK,
    ST_CMP_SCAN,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    EM_ERR,
    EM_APPEND,
    EM_CLEAR,
    EM_READ,
    EM_MOVE,
    EM_FINAL
  } emit_e;

  typedef struct packed {
    logic  latch;
    logic  ctr_inc;
    logic  shift_inc;
    logic  emit;
    emit_e sel;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e in_cmd;
    logic h_zero;
    logic full;
    logic idx_bad;
    logic i_end;
    logic cur_occ;
    logic shift_zero;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/spc_if.sv */
// Request and result channel interfaces of the slot pool with compaction.
`default_nettype none

interface spc_req_if import spc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [IDX_W-1:0]        slot_index;
  logic [EXT_HANDLE_W-1:0] handle;

  modport source (output valid, output cmd, output slot_index, output handle, input ready);
  modport sink (input valid, input cmd, input slot_index, input handle, output ready);
endinterface

interface spc_rsp_if import spc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic [IDX_W-1:0]        result_index;
  logic [EXT_HANDLE_W-1:0] result_handle;
  logic                    moved;
  logic [COUNT_W-1:0]      new_count;
  logic                    last;

  modport source (output valid, output status, output result_index, output result_handle,
                  output moved, output new_count, output last, input ready);
  modport sink (input valid, input status, input result_index, input result_handle,
                input moved, input new_count, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/spc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/spc_ctrl.sv */
// Command sequencer of the slot pool with compaction.
`default_nettype none

module spc_ctrl import spc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  emit_e  sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= EM_ERR;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (status_i.in_cmd)
            CMD_APPEND: state_d = ST_APP_CHK;
            CMD_CLEAR:  state_d = ST_CLR_CHK;
            CMD_READ:   state_d = ST_RD_CHK;
            default:    state_d = ST_CMP_SCAN;
          endcase
        end
      end
      ST_APP_CHK: begin
        if (status_i.h_zero || status_i.full) begin
          sel_d   = EM_ERR;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_APP_SCAN;
        end
      end
      ST_APP_SCAN: begin
        if (status_i.i_end) begin
          sel_d   = EM_ERR;
          state_d = ST_EMIT;
        end else if (!status_i.cur_occ) begin
          sel_d   = EM_APPEND;
          state_d = ST_EMIT;
        end
      end
      ST_CLR_CHK: begin
        sel_d   = status_i.idx_bad ? EM_ERR : EM_CLEAR;
        state_d = ST_EMIT;
      end
      ST_RD_CHK: begin
        sel_d   = status_i.idx_bad ? EM_ERR : EM_READ;
        state_d = ST_EMIT;
      end
      ST_CMP_SCAN: begin
        if (status_i.i_end) begin
          sel_d   = EM_FINAL;
          state_d = ST_EMIT;
        end else if (status_i.cur_occ && !status_i.shift_zero) begin
          sel_d   = EM_MOVE;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = (sel_q == EM_MOVE) ? ST_CMP_SCAN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.latch     = 1'b0;
    cmd_o.ctr_inc   = 1'b0;
    cmd_o.shift_inc = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.sel       = sel_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_APP_SCAN: begin
        cmd_o.ctr_inc = !status_i.i_end && status_i.cur_occ;
      end
      ST_CMP_SCAN: begin
        if (!status_i.i_end) begin
          if (!status_i.cur_occ) begin
            cmd_o.ctr_inc   = 1'b1;
            cmd_o.shift_inc = 1'b1;
          end else if (status_i.shift_zero) begin
            cmd_o.ctr_inc = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.ctr_inc = status_i.out_free && (sel_q == EM_MOVE);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/spc_dp.sv */
// Datapath of the slot pool: slot RAM, occupancy bits, counters and result register.
`default_nettype none

module spc_dp import spc_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEFAULT,
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CMD_W-1:0]        in_cmd_i,
  input  logic [IDX_W-1:0]        in_slot_index_i,
  input  logic [EXT_HANDLE_W-1:0] in_handle_i,
  input  logic                    cfg_we_i,
  input  logic [COUNT_W-1:0]      cfg_wdata_i,
  input  ctrl_cmd_t               cmd_i,
  output dp_status_t              status_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_status_o,
  output logic [IDX_W-1:0]        out_result_index_o,
  output logic [EXT_HANDLE_W-1:0] out_result_handle_o,
  output logic                    out_moved_o,
  output logic [COUNT_W-1:0]      out_new_count_o,
  output logic                    out_last_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [COUNT_W-1:0]     size_q;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [DEPTH-1:0]       occ_q, occ_d;
  cmd_e                   cmd_q;
  logic [IDX_W-1:0]       idx_q;
  logic [HANDLE_BITS-1:0] h_q;
  logic [CW-1:0]          i_q;
  logic [CW-1:0]          shift_q;

  logic                    out_valid_q;
  logic                    out_status_q;
  logic [IDX_W-1:0]        out_index_q;
  logic [EXT_HANDLE_W-1:0] out_handle_q;
  logic                    out_moved_q;
  logic [COUNT_W-1:0]      out_count_q;
  logic                    out_last_q;

  logic                    res_status;
  logic [IDX_W-1:0]        res_index;
  logic [EXT_HANDLE_W-1:0] res_handle;
  logic                    res_moved;
  logic                    res_last;

  logic [CW-1:0]          eff_size;
  logic [CW-1:0]          lim;
  logic [AW-1:0]          cur_addr;
  logic [AW-1:0]          idx_addr;
  logic [AW-1:0]          dst_addr;
  logic [AW-1:0]          raddr;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [HANDLE_BITS-1:0] ram_wdata;
  logic [HANDLE_BITS-1:0] rdata;
  logic                   out_free;

  assign eff_size = (CMPW'(size_q) > CMPW'(DEPTH)) ? CW'(DEPTH) : CW'(size_q);
  assign lim      = (CMPW'(count_q) > CMPW'(DEPTH)) ? CW'(DEPTH) : CW'(count_q);
  assign cur_addr = AW'(i_q);
  assign idx_addr = AW'(idx_q);
  assign dst_addr = AW'(i_q - shift_q);
  assign raddr    = (cmd_q == CMD_COMPACT) ? cur_addr : idx_addr;
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.in_cmd     = cmd_e'(in_cmd_i);
  assign status_o.h_zero     = (h_q == '0);
  assign status_o.full       = (CMPW'(count_q) >= CMPW'(eff_size));
  assign status_o.idx_bad    = (CMPW'(idx_q) >= CMPW'(eff_size));
  assign status_o.i_end      = (cmd_q == CMD_COMPACT) ? (i_q >= lim) : (i_q >= eff_size);
  assign status_o.cur_occ    = occ_q[cur_addr];
  assign status_o.shift_zero = (shift_q == '0);
  assign status_o.out_free   = out_free;

  spc_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    occ_d      = occ_q;
    count_d    = count_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_addr;
    ram_wdata  = h_q;
    res_status = 1'b0;
    res_index  = '0;
    res_handle = '0;
    res_moved  = 1'b0;
    res_last   = 1'b1;
    case (cmd_i.sel)
      EM_ERR: begin
        res_status = 1'b1;
      end
      EM_APPEND: begin
        ram_we          = cmd_i.emit;
        occ_d[cur_addr] = 1'b1;
        count_d         = count_q + COUNT_W'(1);
        res_index       = IDX_W'(i_q);
        res_handle      = EXT_HANDLE_W'(h_q);
      end
      EM_CLEAR: begin
        occ_d[idx_addr] = 1'b0;
      end
      EM_READ: begin
        res_handle = occ_q[idx_addr] ? EXT_HANDLE_W'(rdata) : '0;
      end
      EM_MOVE: begin
        ram_we          = cmd_i.emit;
        ram_waddr       = dst_addr;
        ram_wdata       = rdata;
        occ_d[dst_addr] = 1'b1;
        occ_d[cur_addr] = 1'b0;
        res_index       = IDX_W'(dst_addr);
        res_handle      = EXT_HANDLE_W'(rdata);
        res_moved       = 1'b1;
        res_last        = 1'b0;
      end
      EM_FINAL: begin
        count_d = count_q - COUNT_W'(shift_q);
      end
      default: begin
        res_status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SLOTS_RESET;
      count_q     <= '0;
      occ_q       <= '0;
      cmd_q       <= CMD_APPEND;
      i_q         <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (cmd_i.emit) begin
        count_q <= count_d;
        occ_q   <= occ_d;
      end
      if (cmd_i.latch) begin
        cmd_q   <= cmd_e'(in_cmd_i);
        i_q     <= '0;
        shift_q <= '0;
      end else begin
        if (cmd_i.ctr_inc) begin
          i_q <= i_q + CW'(1);
        end
        if (cmd_i.shift_inc) begin
          shift_q <= shift_q + CW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      idx_q <= in_slot_index_i;
      h_q   <= HANDLE_BITS'(in_handle_i);
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status;
      out_index_q  <= res_index;
      out_handle_q <= res_handle;
      out_moved_q  <= res_moved;
      out_count_q  <= count_d;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_result_index_o  = out_index_q;
  assign out_result_handle_o = out_handle_q;
  assign out_moved_o         = out_moved_q;
  assign out_new_count_o     = out_count_q;
  assign out_last_o          = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/slot_pool_with_compaction_top.sv */
// Top level of the slot pool with compaction: sequencer, datapath and checks.
// One command at a time; the slot scan, one per cycle, paused per move, sets its length.
// Clear and read pass a check state and then the emit state, as does a rejected append.
// Append passes its check, scans past occupied slots to the first empty one, then emits.
// Compact walks the slots, passing the emit state for each moved handle and at the end.
// Reset empties every slot at once, zeroes the count and sets the pool size to 16.
`default_nettype none

module slot_pool_with_compaction_top import spc_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEFAULT,
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  spc_req_if.sink            req_i,
  spc_rsp_if.source          rsp_o,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t  ctl_cmd;
  dp_status_t dp_st;

  spc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (dp_st),
    .cmd_o      (ctl_cmd)
  );

  spc_dp #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_cmd_i            (req_i.cmd),
    .in_slot_index_i     (req_i.slot_index),
    .in_handle_i         (req_i.handle),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .cmd_i               (ctl_cmd),
    .status_o            (dp_st),
    .out_valid_o         (rsp_o.valid),
    .out_ready_i         (rsp_o.ready),
    .out_status_o        (rsp_o.status),
    .out_result_index_o  (rsp_o.result_index),
    .out_result_handle_o (rsp_o.result_handle),
    .out_moved_o         (rsp_o.moved),
    .out_new_count_o     (rsp_o.new_count),
    .out_last_o          (rsp_o.last)
  );

  // A new beat is never taken in the cycle right after one was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while a command was in progress");

  // A result is only loaded when the result register is free or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.emit |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result register overwritten");

  // A move is only reported once at least one hole has been found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_cmd.emit && ctl_cmd.sel == EM_MOVE) |-> !dp_st.shift_zero)
    else $error("move reported without a hole");

  // A loaded move result is never the final beat of its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_cmd.emit && ctl_cmd.sel == EM_MOVE) |=> (rsp_o.valid && rsp_o.moved && !rsp_o.last))
    else $error("move result marked as final");

endmodule

`default_nettype wire
